FILE: rtl/core/pelco_pkg.sv
package pelco_pkg;

    localparam logic [7:0] D_SYNC = 8'hFF;
    localparam logic [7:0] P_STX  = 8'hA0;
    localparam logic [7:0] P_ETX  = 8'hAF;

    // frame format codes for protocol_mode
    localparam logic MODE_D = 1'b0;
    localparam logic MODE_P = 1'b1;

    // byte positions inside a frame
    localparam logic [2:0] POS_HEAD  = 3'd0;
    localparam logic [2:0] POS_ADDR  = 3'd1;
    localparam logic [2:0] POS_CMD1  = 3'd2;
    localparam logic [2:0] POS_CMD2  = 3'd3;
    localparam logic [2:0] POS_DATA1 = 3'd4;
    localparam logic [2:0] POS_DATA2 = 3'd5;
    localparam logic [2:0] POS_D_END = 3'd6;
    localparam logic [2:0] POS_P_END = 3'd7;

    // configuration register index
    localparam logic REG_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] camera_address;
        logic [7:0] command_one;
        logic [7:0] command_two;
        logic [7:0] data_one;
        logic [7:0] data_two;
    } t_cmd_word;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_frame_word;

endpackage

FILE: rtl/core/pelco_command_frame_builder.sv
// Pelco command frame builder. Pulse start with a command word on i_cmd while
// busy is low; the block sends the serial frame one byte per clock on o_frame,
// each byte marked by o_valid for exactly one cycle, with frame_last set on the
// checksum byte. The receiver cannot stall: sample every byte on the cycle that
// o_valid is high, or it is gone. Pelco-D mode (protocol_mode = 0) sends 7
// bytes: 0xFF, address, cmd1, cmd2, data1, data2, sum of bytes 1..5 mod 256.
// Pelco-P mode (protocol_mode = 1) sends 8 bytes: 0xA0, the same five bytes,
// 0xAF, XOR of bytes 1..5. The output port, which moves one byte per clock,
// sets the rate at which commands are taken.
// A one-word holding register lets the next command be accepted while the
// current frame goes out, so frames follow each other with no gap. The first
// byte passes the holding, serializer and output registers. Write protocol_mode
// (APB, byte address 0, bit 0) only while no frame is pending or in flight.
module pelco_command_frame_builder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  pelco_pkg::t_cmd_word   i_cmd,
    // frame byte channel
    output logic                   o_valid,
    output pelco_pkg::t_frame_word o_frame,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // configuration
    logic r_mode;

    // holding register for the next command word
    logic                 r_pend_valid;
    pelco_pkg::t_cmd_word r_pend;

    // serializer: current command, its checksum and the byte position
    logic                 r_active;
    pelco_pkg::t_cmd_word r_cur;
    logic [7:0]           r_chk;
    logic [2:0]           r_idx;

    // output register
    logic                   r_out_valid;
    pelco_pkg::t_frame_word r_out;

    logic                   accept;
    logic                   at_end;
    logic                   load_ok;
    logic                   cfg_write;
    logic [2:0]             end_pos;
    logic [7:0]             n_chk;
    pelco_pkg::t_frame_word n_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pelco_pkg::REG_MODE) ? {31'd0, r_mode} : 32'd0;

    // last byte position depends on the frame format
    assign end_pos = (r_mode == pelco_pkg::MODE_P) ? pelco_pkg::POS_P_END
                                                   : pelco_pkg::POS_D_END;
    assign at_end  = r_active && (r_idx == end_pos);

    // serializer takes a new word when idle or when sending its final byte
    assign load_ok = !r_active || at_end;
    assign busy    = r_pend_valid && !load_ok;
    assign accept  = start && !busy;

    // checksum of the held word, computed on its way into the serializer
    always_comb begin
        if (r_mode == pelco_pkg::MODE_P) begin
            n_chk = r_pend.camera_address ^ r_pend.command_one ^ r_pend.command_two
                  ^ r_pend.data_one ^ r_pend.data_two;
        end else begin
            n_chk = r_pend.camera_address + r_pend.command_one + r_pend.command_two
                  + r_pend.data_one + r_pend.data_two;
        end
    end

    // pick the byte at the current position
    always_comb begin
        n_out.frame_last = 1'b0;
        case (r_idx)
            pelco_pkg::POS_HEAD: begin
                n_out.frame_byte = (r_mode == pelco_pkg::MODE_P) ? pelco_pkg::P_STX
                                                                 : pelco_pkg::D_SYNC;
            end
            pelco_pkg::POS_ADDR:  n_out.frame_byte = r_cur.camera_address;
            pelco_pkg::POS_CMD1:  n_out.frame_byte = r_cur.command_one;
            pelco_pkg::POS_CMD2:  n_out.frame_byte = r_cur.command_two;
            pelco_pkg::POS_DATA1: n_out.frame_byte = r_cur.data_one;
            pelco_pkg::POS_DATA2: n_out.frame_byte = r_cur.data_two;
            pelco_pkg::POS_D_END: begin
                // ETX in P mode, checksum in D mode
                if (r_mode == pelco_pkg::MODE_P) begin
                    n_out.frame_byte = pelco_pkg::P_ETX;
                end else begin
                    n_out.frame_byte = r_chk;
                    n_out.frame_last = 1'b1;
                end
            end
            pelco_pkg::POS_P_END: begin
                n_out.frame_byte = r_chk;
                n_out.frame_last = 1'b1;
            end
            default: n_out.frame_byte = 8'd0;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pelco_pkg::MODE_D;
            r_pend_valid <= 1'b0;
            r_active     <= 1'b0;
            r_idx        <= pelco_pkg::POS_HEAD;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == pelco_pkg::REG_MODE)) begin
                r_mode <= pwdata[0];
            end

            // hold a new word; drop the held one once it moves on
            if (accept) begin
                r_pend_valid <= 1'b1;
            end else if (load_ok) begin
                r_pend_valid <= 1'b0;
            end

            // advance the serializer, or reload it from the holding register
            if (load_ok) begin
                r_active <= r_pend_valid;
                r_idx    <= pelco_pkg::POS_HEAD;
            end else begin
                r_idx <= r_idx + 3'd1;
            end

            r_out_valid <= r_active;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= i_cmd;
        end
        if (load_ok && r_pend_valid) begin
            r_cur <= r_pend;
            r_chk <= n_chk;
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_frame = r_out;

    // an accepted word is always held on the next cycle
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_pend_valid)
        else $error("accepted command word not held");

    // every serializer cycle yields exactly one strobed byte
    a_byte_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |=> o_valid)
        else $error("serializer active without output byte");

    // final byte without a waiting word leaves the serializer idle
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (at_end && !r_pend_valid) |=> (!r_active && o_valid && o_frame.frame_last))
        else $error("frame end not marked or serializer still running");

    // the last marker appears only on the final frame position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !at_end) |=> !o_frame.frame_last)
        else $error("last marker before frame end");

endmodule
